/* hdl/led_chain_frame_builder_macros.svh */
// Assertion macros shared by the LED chain frame builder RTL.
`ifndef LED_CHAIN_FRAME_BUILDER_MACROS_SVH
`define LED_CHAIN_FRAME_BUILDER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LCFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LCFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lcfb_pkg.sv */
// Package with the shared types and constants of the LED chain frame builder.
`timescale 1ns / 1ps

package lcfb_pkg;

	// Default sizes.
	localparam int MAX_MODULE_LEDS_DEF = 16;
	localparam int END_WORDS_DEF       = 1;

	// Command opcodes.
	localparam logic [1:0] OP_SET_COLOUR = 2'd0;
	localparam logic [1:0] OP_SET_BRIGHT = 2'd1;
	localparam logic [1:0] OP_SERVICE    = 2'd2;

	// Frame word constants.
	localparam logic [2:0]  LED_HEADER  = 3'b111;
	localparam logic [4:0]  BRI_RESET   = 5'd31;
	localparam logic [31:0] START_WORD  = 32'h0000_0000;
	localparam logic [31:0] END_WORD    = 32'hFFFF_FFFF;

	// One command word.
	typedef struct packed {
		logic [1:0] opcode;
		logic [4:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] brightness_value;
	} cmd_word_t;

	// One frame word.
	typedef struct packed {
		logic [31:0] frame_word;
		logic        last_word;
	} frame_word_t;

endpackage

/* hdl/led_chain_frame_builder.sv */
// Top level of the LED chain frame builder: color store, brightness and frame sequencer.
//
//  port group           | dir | carries
//  ---------------------+-----+------------------------------------------------
//  cmd / cmd_valid      | in  | command word (color, brightness or service)
//  frame / frame_valid  | out | frame word and last-word flag
//  cfg_wr_en / _data    | in  | module LED count register
//
// Color and brightness commands emit nothing. A service on a dirty frame emits a start
// word, min(module_leds, MAX_MODULE_LEDS) + 1 LED words and END_WORDS end words, one word
// per cycle while the frame side does not stall, paced by the single read port of the
// color store and the one output register. A clean service or an unused opcode emits
// nothing. After reset all colors read as zero, brightness is 31 and the frame is dirty.
// A stall on the frame side freezes the sequencer; cmd_stall is high while it runs.
`timescale 1ns / 1ps
`include "led_chain_frame_builder_macros.svh"

module led_chain_frame_builder
	import lcfb_pkg::*;
#(
	parameter int MAX_MODULE_LEDS = MAX_MODULE_LEDS_DEF,
	parameter int END_WORDS       = END_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_word_t   cmd,
	output logic        frame_valid,
	input  logic        frame_stall,
	output frame_word_t frame,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data
);

	localparam int SLOTS  = MAX_MODULE_LEDS + 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = $bits(cmd.led_index);
	localparam int CMP_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
	localparam int END_W  = (END_WORDS > 1) ? $clog2(END_WORDS) : 1;
	localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_MODULE_LEDS);
	localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(MAX_MODULE_LEDS);
	localparam logic [END_W-1:0]  END_LAST = END_W'(END_WORDS - 1);

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_LED   = 2'd2;
	localparam logic [1:0] S_END   = 2'd3;

	logic [1:0]        state_q;
	logic [4:0]        module_leds_q;
	logic [4:0]        bri_q;
	logic              dirty_q;
	logic [SLOTS-1:0]  valid_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] limit_q;
	logic [END_W-1:0]  ecnt_q;
	logic              rd_valid_q;
	logic              frame_valid_q;
	frame_word_t       frame_q;

	logic              cmd_acc;
	logic              out_free;
	logic [CMP_W-1:0]  cfg_ext;
	logic [CMP_W-1:0]  limit_c;
	logic [CMP_W-1:0]  idx_ext;
	logic [SLOT_W-1:0] wr_addr;
	logic              wr_ok;
	logic              ram_we;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [23:0]       ram_rdata;
	logic [23:0]       colour;
	logic              at_limit;
	logic              load;
	frame_word_t       load_word;
	logic              svc_go;
	logic              end_go;
	logic              cnt_ok;
	logic              last_out;

	assign cmd_stall   = (state_q != S_IDLE);
	assign cmd_acc     = cmd_valid && !cmd_stall;
	assign out_free    = !frame_valid_q || !frame_stall;
	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

	// Highest LED index in use, with the count clamped to the store size.
	assign cfg_ext = CMP_W'(module_leds_q);
	assign limit_c = (cfg_ext > MAX_CMP) ? MAX_CMP : cfg_ext;
	assign idx_ext = CMP_W'(cmd.led_index);
	assign wr_addr = idx_ext[SLOT_W-1:0];
	assign wr_ok   = (idx_ext <= limit_c);
	assign ram_we  = cmd_acc && (cmd.opcode == OP_SET_COLOUR) && wr_ok;

	// Shared compare: has the LED counter reached the last LED in use?
	assign at_limit = (cnt_q == limit_q);

	// Store read requests and the word the sequencer loads into the output register.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		load      = 1'b0;
		load_word = '{frame_word: START_WORD, last_word: 1'b0};
		unique case (state_q)
			S_IDLE: begin
			end
			S_START: begin
				ram_re    = out_free;
				ram_raddr = '0;
				load      = out_free;
			end
			S_LED: begin
				ram_re    = out_free && !at_limit;
				ram_raddr = SLOT_W'(cnt_q + 1'b1);
				load      = out_free;
				load_word = '{frame_word: {LED_HEADER, bri_q, colour[7:0], colour[15:8],
					colour[23:16]}, last_word: 1'b0};
			end
			S_END: begin
				load      = out_free;
				load_word = '{frame_word: END_WORD, last_word: (ecnt_q == END_LAST)};
			end
			default: begin
			end
		endcase
	end

	// An entry never written reads as zero.
	assign colour = rd_valid_q ? ram_rdata : 24'd0;

	lcfb_ram #(
		.WIDTH(24),
		.DEPTH(SLOTS)
	) u_colour_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata({cmd.red, cmd.green, cmd.blue}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_leds_q <= '0;
		end else if (cfg_wr_en) begin
			module_leds_q <= cfg_wr_data;
		end
	end

	// Per-entry written flags and the flag that follows the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_q <= valid_q[ram_raddr];
			end
		end
	end

	// Command handling and the frame sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bri_q   <= BRI_RESET;
			dirty_q <= 1'b1;
			cnt_q   <= '0;
			limit_q <= '0;
			ecnt_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (cmd.opcode == OP_SET_COLOUR) begin
							if (wr_ok) begin
								dirty_q <= 1'b1;
							end
						end else if (cmd.opcode == OP_SET_BRIGHT) begin
							bri_q   <= cmd.brightness_value[4:0];
							dirty_q <= 1'b1;
						end else if (cmd.opcode == OP_SERVICE && dirty_q) begin
							dirty_q <= 1'b0;
							limit_q <= limit_c[SLOT_W-1:0];
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					if (out_free) begin
						cnt_q   <= '0;
						state_q <= S_LED;
					end
				end
				S_LED: begin
					if (out_free) begin
						if (at_limit) begin
							ecnt_q  <= '0;
							state_q <= S_END;
						end else begin
							cnt_q <= SLOT_W'(cnt_q + 1'b1);
						end
					end
				end
				S_END: begin
					if (out_free) begin
						if (ecnt_q == END_LAST) begin
							state_q <= S_IDLE;
						end else begin
							ecnt_q <= END_W'(ecnt_q + 1'b1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loads a new word when empty or when its word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (load) begin
			frame_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= load_word;
		end
	end

	// Conditions watched by the checks below.
	assign svc_go   = cmd_acc && (cmd.opcode == OP_SERVICE) && dirty_q;
	assign end_go   = (state_q == S_END) && out_free && (ecnt_q == END_LAST);
	assign cnt_ok   = (cnt_q <= limit_q) && (limit_q <= MAX_SLOT);
	assign last_out = frame_valid_q && frame_q.last_word && (state_q == S_IDLE);

	// Checks on the sequencer.
	`LCFB_ASSERT_NEXT(a_service_starts, svc_go, state_q == S_START && !dirty_q, "frame not started")
	`LCFB_ASSERT_NOW(a_cnt_in_range, state_q == S_LED, cnt_ok, "LED counter passed the last LED")
	`LCFB_ASSERT_NEXT(a_last_word_out, end_go, last_out, "final end word not flagged")

endmodule

/* hdl/lcfb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lcfb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 17,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
